FILE: rtl/core/tce_pkg.sv
package tce_pkg;

    // Instruction codes
    typedef enum logic [3:0] {
        OP_LOAD_MEM  = 4'd0,   // Rn <- mem[b]
        OP_STORE_MEM = 4'd1,   // mem[a] <- Rm
        OP_LOAD_IND  = 4'd2,   // Rn <- mem[Rm]
        OP_STORE_IND = 4'd3,   // mem[Rn] <- Rm
        OP_LOAD_LIT  = 4'd4,   // Rn <- b
        OP_MOVE      = 4'd5,   // Rn <- Rm
        OP_ADD       = 4'd6,
        OP_SUB       = 4'd7,
        OP_MUL       = 4'd8,
        OP_DIV       = 4'd9,
        OP_AND       = 4'd10,
        OP_OR        = 4'd11,
        OP_JZ        = 4'd12,
        OP_CMP       = 4'd13,
        OP_LESS      = 4'd14,
        OP_NOP       = 4'd15
    } kind_t;

    localparam int BYTE_W     = 8;
    localparam int REG_IDX_W  = 4;
    localparam int DIV_STEPS  = 8;
    localparam int DIV_CNT_W  = 3;
    localparam int LUT_DEPTH  = 256;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  first_operand;
        logic [BYTE_W-1:0]  second_operand;
        logic [BYTE_W-1:0]  current_pc;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]     next_pc;
        logic                  divide_by_zero;
        logic                  reg_written;
        logic [REG_IDX_W-1:0]  reg_index;
        logic                  mem_written;
        logic [BYTE_W-1:0]     mem_address;
        logic [BYTE_W-1:0]     written_value;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // latch the request
        logic capture;    // latch operands, arm divider
        logic div_step;   // one quotient bit
        logic commit;     // write back and issue result
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_go;     // DIV with a nonzero divisor
        logic div_last;   // final quotient bit this cycle
    } sts_t;

endpackage

FILE: rtl/core/tce_ram.sv
module tce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/tce_ctrl.sv
module tce_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tce_pkg::sts_t sts,
    output tce_pkg::cmd_t cmd,
    output logic          busy
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REG_RD = 5'b00010,
        ST_MEM_RD = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_EXEC   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_REG_RD;
                end
            end
            ST_REG_RD:
            begin
                state_next = ST_MEM_RD;
            end
            ST_MEM_RD:
            begin
                cmd.capture = 1'b1;
                state_next  = sts.div_go ? ST_DIVIDE : ST_EXEC;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/tce_datapath.sv
module tce_datapath #(
    parameter int NUM_REGS   = 16,
    parameter int DATA_WORDS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tce_pkg::req_t request,
    input  tce_pkg::cmd_t cmd,
    output tce_pkg::sts_t sts,
    output logic          done,
    output tce_pkg::rsp_t result
);

    localparam int BW = tce_pkg::BYTE_W;
    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int MW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int CW = tce_pkg::DIV_CNT_W;

    // Wrap tables: byte value to register / memory index
    logic [RW-1:0] reg_lut [tce_pkg::LUT_DEPTH];
    logic [MW-1:0] mem_lut [tce_pkg::LUT_DEPTH];

    for (genvar i = 0; i < tce_pkg::LUT_DEPTH; i++)
    begin : g_lut
        assign reg_lut[i] = RW'(i % NUM_REGS);
        assign mem_lut[i] = MW'(i % DATA_WORDS);
    end

    // Latched request
    tce_pkg::kind_t kind_reg;
    logic [RW-1:0]  n_reg;
    logic [RW-1:0]  m_reg;
    logic [MW-1:0]  a_ix_reg;
    logic [BW-1:0]  b_reg;
    logic [BW-1:0]  pc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= request.kind;
            n_reg    <= reg_lut[request.first_operand];
            m_reg    <= reg_lut[request.second_operand];
            a_ix_reg <= mem_lut[request.first_operand];
            b_reg    <= request.second_operand;
            pc_reg   <= request.current_pc;
        end
    end

    // Register file: two copies for two read ports, valid bits for reset
    logic [BW-1:0]       rf_a_rdata;
    logic [BW-1:0]       rf_b_rdata;
    logic [NUM_REGS-1:0] rf_valid_reg;
    logic                rf_a_vld_reg;
    logic                rf_b_vld_reg;
    logic                rf_we;
    logic [BW-1:0]       wr_val;

    tce_ram #(.WIDTH(BW), .DEPTH(NUM_REGS)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (n_reg),
        .wdata (wr_val),
        .raddr (n_reg),
        .rdata (rf_a_rdata)
    );

    tce_ram #(.WIDTH(BW), .DEPTH(NUM_REGS)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (n_reg),
        .wdata (wr_val),
        .raddr (m_reg),
        .rdata (rf_b_rdata)
    );

    logic [BW-1:0] rn_rd;
    logic [BW-1:0] rm_rd;

    assign rn_rd = rf_a_vld_reg ? rf_a_rdata : '0;
    assign rm_rd = rf_b_vld_reg ? rf_b_rdata : '0;

    // Data memory
    logic [MW-1:0]         dm_raddr;
    logic [MW-1:0]         dm_waddr;
    logic [BW-1:0]         dm_rdata;
    logic [DATA_WORDS-1:0] dm_valid_reg;
    logic                  dm_vld_reg;
    logic                  dm_we;
    logic [BW-1:0]         mem_val;

    assign dm_raddr = (kind_reg == tce_pkg::OP_LOAD_IND) ? mem_lut[rm_rd] : mem_lut[b_reg];

    tce_ram #(.WIDTH(BW), .DEPTH(DATA_WORDS)) u_dm (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (wr_val),
        .raddr (dm_raddr),
        .rdata (dm_rdata)
    );

    assign mem_val = dm_vld_reg ? dm_rdata : '0;

    // Valid bits follow the read address like the RAM data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            dm_valid_reg <= '0;
            rf_a_vld_reg <= 1'b0;
            rf_b_vld_reg <= 1'b0;
            dm_vld_reg   <= 1'b0;
        end
        else
        begin
            rf_a_vld_reg <= rf_valid_reg[n_reg];
            rf_b_vld_reg <= rf_valid_reg[m_reg];
            dm_vld_reg   <= dm_valid_reg[dm_raddr];
            if (rf_we)
            begin
                rf_valid_reg[n_reg] <= 1'b1;
            end
            if (dm_we)
            begin
                dm_valid_reg[dm_waddr] <= 1'b1;
            end
        end
    end

    // Operands and restoring divider, one quotient bit per cycle
    logic [BW-1:0] rn_reg;
    logic [BW-1:0] rm_reg;
    logic [BW-1:0] quo_reg;
    logic [BW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic [BW:0]   rem_sh;
    logic [BW:0]   diff;

    assign rem_sh = {rem_reg, quo_reg[BW-1]};
    assign diff   = rem_sh - {1'b0, rm_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rn_reg  <= rn_rd;
            rm_reg  <= rm_rd;
            quo_reg <= rn_rd;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (!diff[BW])
            begin
                rem_reg <= diff[BW-1:0];
                quo_reg <= {quo_reg[BW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[BW-1:0];
                quo_reg <= {quo_reg[BW-2:0], 1'b0};
            end
        end
    end

    assign sts.div_go   = (kind_reg == tce_pkg::OP_DIV) && (rm_rd != '0);
    assign sts.div_last = (cnt_reg == CW'(tce_pkg::DIV_STEPS - 1));

    // Execute decode
    logic          rw;
    logic          mw;
    logic          dz;
    logic [BW-1:0] npc;

    always_comb
    begin
        rw       = 1'b0;
        mw       = 1'b0;
        dz       = 1'b0;
        wr_val   = '0;
        dm_waddr = a_ix_reg;
        npc      = pc_reg;
        unique case (kind_reg) inside
            tce_pkg::OP_LOAD_MEM, tce_pkg::OP_LOAD_IND:
            begin
                rw     = 1'b1;
                wr_val = mem_val;
            end
            tce_pkg::OP_STORE_MEM:
            begin
                mw     = 1'b1;
                wr_val = rm_reg;
            end
            tce_pkg::OP_STORE_IND:
            begin
                mw       = 1'b1;
                dm_waddr = mem_lut[rn_reg];
                wr_val   = rm_reg;
            end
            tce_pkg::OP_LOAD_LIT:
            begin
                rw     = 1'b1;
                wr_val = b_reg;
            end
            tce_pkg::OP_MOVE:
            begin
                rw     = 1'b1;
                wr_val = rm_reg;
            end
            tce_pkg::OP_ADD:
            begin
                rw     = 1'b1;
                wr_val = rn_reg + rm_reg;
            end
            tce_pkg::OP_SUB:
            begin
                rw     = 1'b1;
                wr_val = rn_reg - rm_reg;
            end
            tce_pkg::OP_MUL:
            begin
                rw     = 1'b1;
                wr_val = rn_reg * rm_reg;
            end
            tce_pkg::OP_DIV:
            begin
                if (rm_reg != '0)
                begin
                    rw     = 1'b1;
                    wr_val = quo_reg;
                end
                else
                begin
                    dz = 1'b1;
                end
            end
            tce_pkg::OP_AND:
            begin
                rw     = 1'b1;
                wr_val = rn_reg & rm_reg;
            end
            tce_pkg::OP_OR:
            begin
                rw     = 1'b1;
                wr_val = rn_reg | rm_reg;
            end
            tce_pkg::OP_JZ:
            begin
                if (rn_reg == '0)
                begin
                    npc = pc_reg + b_reg - BW'(1);
                end
            end
            tce_pkg::OP_LESS:
            begin
                if (rn_reg < rm_reg)
                begin
                    rw     = 1'b1;
                    wr_val = rm_reg;
                end
            end
            tce_pkg::OP_CMP, tce_pkg::OP_NOP:
            begin
                rw = 1'b0;
            end
            default:
            begin
                rw = 1'b0;
            end
        endcase
    end

    assign rf_we = cmd.commit && rw;
    assign dm_we = cmd.commit && mw;

    // Result register and strobe
    tce_pkg::rsp_t rsp_reg;
    logic          done_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.next_pc        <= npc;
            rsp_reg.divide_by_zero <= dz;
            rsp_reg.reg_written    <= rw;
            rsp_reg.reg_index      <= rw ? tce_pkg::REG_IDX_W'(n_reg) : '0;
            rsp_reg.mem_written    <= mw;
            rsp_reg.mem_address    <= mw ? BW'(dm_waddr) : '0;
            rsp_reg.written_value  <= wr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

FILE: rtl/core/tiny_cpu_execute_unit.sv
// Executes one decoded 8-bit instruction per request against a register file
// and a data memory that both read as zero after reset. A request is taken when
// start is high and busy is low; the result appears on result for exactly one
// cycle with done high and must be captured then, as it cannot be held off.
// Every instruction passes through request latch, register read, operand/memory
// read and execute, and DIV with a nonzero divisor also goes through the
// one-bit-per-cycle restoring divider before execute. A new request can be
// accepted in the cycle done is high, but not while busy is high, so one
// instruction is finished before the next is taken.
module tiny_cpu_execute_unit #(
    parameter int NUM_REGS   = 16,
    parameter int DATA_WORDS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  tce_pkg::req_t request,
    output logic          done,
    output tce_pkg::rsp_t result
);

    tce_pkg::cmd_t cmd;
    tce_pkg::sts_t sts;

    tce_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    tce_datapath #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WORDS (DATA_WORDS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

endmodule
